### rtl/script_token_scanner_unit_macros.svh
// Assertion macros used by the scanner queue.
`ifndef SCRIPT_TOKEN_SCANNER_UNIT_MACROS_SVH
`define SCRIPT_TOKEN_SCANNER_UNIT_MACROS_SVH

// Same-cycle implication, checked on every clock outside reset.
`define STSU_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("scanner check failed");

// Next-cycle implication, checked on every clock outside reset.
`define STSU_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("scanner check failed");

`endif

### rtl/stsu_pkg.sv
// Types, codes and character helpers of the script token scanner.
package stsu_pkg;

    typedef struct packed {
        logic       operation;
        logic [7:0] source_byte;
    } src_beat_t;

    typedef struct packed {
        logic [5:0]  token_kind;
        logic [23:0] start_offset;
        logic [15:0] token_length;
        logic [19:0] line_number;
        logic        last_of_run;
    } tok_beat_t;

    localparam int MAX_TOK = 3;

    typedef struct packed {
        logic [1:0]                count;
        tok_beat_t [MAX_TOK-1:0]   tok;
    } tok_push_t;

    localparam int QUEUE_DEPTH = 16;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
    // Room for the token burst of the item in flight plus the one accepted now.
    localparam int ACCEPT_MAX  = QUEUE_DEPTH - 2 * MAX_TOK;

    localparam logic       OP_BYTE = 1'b0;
    localparam logic       OP_END  = 1'b1;
    localparam logic [0:0] REG_FIRST_LINE = 1'b0;

    typedef enum logic [2:0] {
        MODE_IDLE,
        MODE_PEND,
        MODE_COMMENT,
        MODE_STRING,
        MODE_IDENT,
        MODE_INT,
        MODE_DOT,
        MODE_FRAC
    } scan_mode_t;

    localparam logic [5:0] KIND_LPAREN  = 6'd0;
    localparam logic [5:0] KIND_RPAREN  = 6'd1;
    localparam logic [5:0] KIND_LBRACK  = 6'd2;
    localparam logic [5:0] KIND_RBRACK  = 6'd3;
    localparam logic [5:0] KIND_COLON   = 6'd4;
    localparam logic [5:0] KIND_LBRACE  = 6'd5;
    localparam logic [5:0] KIND_RBRACE  = 6'd7;
    localparam logic [5:0] KIND_COMMA   = 6'd9;
    localparam logic [5:0] KIND_DOT     = 6'd10;
    localparam logic [5:0] KIND_MINUS   = 6'd11;
    localparam logic [5:0] KIND_PLUS    = 6'd13;
    localparam logic [5:0] KIND_SEMI    = 6'd14;
    localparam logic [5:0] KIND_STAR    = 6'd15;
    localparam logic [5:0] KIND_BANG    = 6'd16;
    localparam logic [5:0] KIND_EQUAL   = 6'd18;
    localparam logic [5:0] KIND_LESS    = 6'd20;
    localparam logic [5:0] KIND_GREATER = 6'd22;
    localparam logic [5:0] KIND_SLASH   = 6'd24;
    localparam logic [5:0] KIND_STRING  = 6'd25;
    localparam logic [5:0] KIND_NUMBER  = 6'd26;
    localparam logic [5:0] KIND_IDENT   = 6'd27;
    localparam logic [5:0] KIND_KW0     = 6'd28;
    localparam logic [5:0] KIND_EOF     = 6'd47;

    localparam logic [7:0]  CH_NL    = 8'h0A;
    localparam logic [7:0]  CH_CR    = 8'h0D;
    localparam logic [15:0] LEN_MAX  = 16'hFFFF;
    localparam logic [19:0] LINE_MAX = 20'hFFFFF;

    localparam int NUM_KW = 19;
    localparam int KW_LEN [NUM_KW] = '{3, 5, 4, 5, 3, 3, 2, 3, 2, 5, 6, 5, 4, 4, 3, 5, 6, 8, 7};
    localparam logic [63:0] KW_TEXT [NUM_KW] = '{
        "and", "class", "else", "false", "for", "fun", "if", "nil", "or",
        "print", "return", "super", "this", "true", "var", "while",
        "Listen", "Delegate", "Animate"
    };

    function automatic logic is_digit(input logic [7:0] b);
        return (b >= "0") && (b <= "9");
    endfunction

    function automatic logic is_alpha(input logic [7:0] b);
        return ((b >= "a") && (b <= "z")) || ((b >= "A") && (b <= "Z"));
    endfunction

    function automatic logic is_word(input logic [7:0] b);
        return is_alpha(b) || is_digit(b) || (b == "_");
    endfunction

    function automatic logic [5:0] single_kind(input logic [7:0] op);
        logic [5:0] k;
        case (op)
            "{":     k = KIND_LBRACE;
            "}":     k = KIND_RBRACE;
            "-":     k = KIND_MINUS;
            "!":     k = KIND_BANG;
            "=":     k = KIND_EQUAL;
            "<":     k = KIND_LESS;
            ">":     k = KIND_GREATER;
            default: k = KIND_SLASH;
        endcase
        return k;
    endfunction

    // head holds the first eight word bytes, first byte in the top byte.
    function automatic logic [5:0] word_kind(input logic [63:0] head, input logic [15:0] len);
        logic [5:0] k;
        logic       found;
        k     = KIND_IDENT;
        found = 1'b0;
        for (int i = 0; i < NUM_KW; i++) begin
            if (!found && (len == 16'(KW_LEN[i]))
                && ((head >> (8 * (8 - KW_LEN[i]))) == KW_TEXT[i])) begin
                k     = KIND_KW0 + 6'(i);
                found = 1'b1;
            end
        end
        return k;
    endfunction

    function automatic tok_beat_t make_tok(input logic [5:0] kind, input logic [23:0] start,
                                           input logic [15:0] len, input logic [19:0] line);
        tok_beat_t t;
        t.token_kind   = kind;
        t.start_offset = start;
        t.token_length = len;
        t.line_number  = line;
        t.last_of_run  = 1'b0;
        return t;
    endfunction

endpackage

### rtl/stsu_core.sv
// Scanner state and per-byte token logic between the input register and the queue.
module stsu_core #(
    parameter int KEYWORD_BYTES = 8
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  item_load,
    input  stsu_pkg::src_beat_t   item_in,
    input  logic                  cfg_we,
    input  logic                  cfg_bit,
    output logic                  first_line,
    output stsu_pkg::tok_push_t   push
);
    import stsu_pkg::*;

    logic        item_vld_reg;
    src_beat_t   item_reg;
    scan_mode_t  mode_reg, mode_next;
    logic [7:0]  pend_reg, pend_next;
    logic [23:0] start_reg, start_next;
    logic [23:0] off_reg, off_next;
    logic [19:0] line_reg, line_next;
    logic [15:0] wlen_reg, wlen_next;
    logic [7:0]  wbuf_reg [KEYWORD_BYTES];
    logic [7:0]  wbuf_next [KEYWORD_BYTES];
    logic        fresh_reg, fresh_next;
    logic        first_line_reg;
    logic [63:0] head;
    logic [5:0]  wkind;
    tok_beat_t   tk [MAX_TOK];
    logic [1:0]  cnt;
    logic        taken;
    logic [7:0]  b;

    always_comb
    begin
        for (int i = 0; i < 8; i++)
        begin
            head[63 - 8*i -: 8] = wbuf_reg[i];
        end
    end

    assign wkind = word_kind(head, wlen_reg);
    assign b     = item_reg.source_byte;

    always_comb
    begin
        mode_next  = mode_reg;
        pend_next  = pend_reg;
        start_next = start_reg;
        off_next   = off_reg;
        line_next  = line_reg;
        wlen_next  = wlen_reg;
        wbuf_next  = wbuf_reg;
        fresh_next = fresh_reg;
        for (int i = 0; i < MAX_TOK; i++)
        begin
            tk[i] = '0;
        end
        cnt   = 2'd0;
        taken = 1'b1;
        if (item_vld_reg)
        begin
            if (item_reg.operation == OP_END)
            begin
                // flush the open token, then eof
                case (mode_reg)
                    MODE_PEND:
                    begin
                        tk[cnt] = make_tok(single_kind(pend_reg), start_reg, 16'd1, line_reg);
                        cnt = cnt + 2'd1;
                    end
                    MODE_IDENT:
                    begin
                        tk[cnt] = make_tok(wkind, start_reg, wlen_reg, line_reg);
                        cnt = cnt + 2'd1;
                    end
                    MODE_INT, MODE_FRAC:
                    begin
                        tk[cnt] = make_tok(KIND_NUMBER, start_reg, wlen_reg, line_reg);
                        cnt = cnt + 2'd1;
                    end
                    MODE_DOT:
                    begin
                        tk[cnt] = make_tok(KIND_NUMBER, start_reg, wlen_reg, line_reg);
                        cnt = cnt + 2'd1;
                        tk[cnt] = make_tok(KIND_DOT, off_reg - 24'd1, 16'd1, line_reg);
                        cnt = cnt + 2'd1;
                    end
                    default:
                    begin
                    end
                endcase
                tk[cnt] = make_tok(KIND_EOF, 24'd0, 16'd0, line_reg);
                cnt = cnt + 2'd1;
                mode_next  = MODE_IDLE;
                start_next = '0;
                off_next   = '0;
                wlen_next  = '0;
                line_next  = {19'd0, first_line_reg};
                fresh_next = 1'b1;
            end
            else
            begin
                fresh_next = 1'b0;
                case (mode_reg)
                    MODE_PEND:
                    begin
                        if ((pend_reg == "/") && (b == "/"))
                        begin
                            mode_next = MODE_COMMENT;
                        end
                        else if (((pend_reg == "{") && (b == "{"))
                                 || ((pend_reg == "}") && (b == "}"))
                                 || ((pend_reg == "-") && (b == ">"))
                                 || (((pend_reg == "!") || (pend_reg == "=")
                                      || (pend_reg == "<") || (pend_reg == ">"))
                                     && (b == "=")))
                        begin
                            tk[cnt] = make_tok(single_kind(pend_reg) + 6'd1, start_reg, 16'd2,
                                               line_reg);
                            cnt = cnt + 2'd1;
                            mode_next = MODE_IDLE;
                        end
                        else
                        begin
                            tk[cnt] = make_tok(single_kind(pend_reg), start_reg, 16'd1, line_reg);
                            cnt = cnt + 2'd1;
                            mode_next = MODE_IDLE;
                            taken = 1'b0;
                        end
                    end
                    MODE_COMMENT:
                    begin
                        if (b == CH_NL)
                        begin
                            mode_next = MODE_IDLE;
                            taken = 1'b0;
                        end
                    end
                    MODE_STRING:
                    begin
                        if (wlen_reg != LEN_MAX)
                        begin
                            wlen_next = wlen_reg + 16'd1;
                        end
                        if (b == "\"")
                        begin
                            tk[cnt] = make_tok(KIND_STRING, start_reg, wlen_next, line_reg);
                            cnt = cnt + 2'd1;
                            mode_next = MODE_IDLE;
                        end
                        else if ((b == CH_NL) && (line_reg != LINE_MAX))
                        begin
                            line_next = line_reg + 20'd1;
                        end
                    end
                    MODE_IDENT:
                    begin
                        if (is_word(b))
                        begin
                            for (int i = 0; i < KEYWORD_BYTES; i++)
                            begin
                                if (wlen_reg == 16'(i))
                                begin
                                    wbuf_next[i] = b;
                                end
                            end
                            if (wlen_reg != LEN_MAX)
                            begin
                                wlen_next = wlen_reg + 16'd1;
                            end
                        end
                        else
                        begin
                            tk[cnt] = make_tok(wkind, start_reg, wlen_reg, line_reg);
                            cnt = cnt + 2'd1;
                            mode_next = MODE_IDLE;
                            taken = 1'b0;
                        end
                    end
                    MODE_INT, MODE_FRAC:
                    begin
                        if (is_digit(b))
                        begin
                            if (wlen_reg != LEN_MAX)
                            begin
                                wlen_next = wlen_reg + 16'd1;
                            end
                        end
                        else if ((b == ".") && (mode_reg == MODE_INT))
                        begin
                            mode_next = MODE_DOT;
                        end
                        else
                        begin
                            tk[cnt] = make_tok(KIND_NUMBER, start_reg, wlen_reg, line_reg);
                            cnt = cnt + 2'd1;
                            mode_next = MODE_IDLE;
                            taken = 1'b0;
                        end
                    end
                    MODE_DOT:
                    begin
                        if (is_digit(b))
                        begin
                            // the dot and the digit both join the number
                            if (wlen_reg >= LEN_MAX - 16'd1)
                            begin
                                wlen_next = LEN_MAX;
                            end
                            else
                            begin
                                wlen_next = wlen_reg + 16'd2;
                            end
                            mode_next = MODE_FRAC;
                        end
                        else
                        begin
                            tk[cnt] = make_tok(KIND_NUMBER, start_reg, wlen_reg, line_reg);
                            cnt = cnt + 2'd1;
                            tk[cnt] = make_tok(KIND_DOT, off_reg - 24'd1, 16'd1, line_reg);
                            cnt = cnt + 2'd1;
                            mode_next = MODE_IDLE;
                            taken = 1'b0;
                        end
                    end
                    default:
                    begin
                        mode_next = MODE_IDLE;
                        taken = 1'b0;
                    end
                endcase

                if (!taken)
                begin
                    // scan the byte as the start of a new token
                    start_next = off_reg;
                    wlen_next  = 16'd1;
                    case (b) inside
                        "(":
                        begin
                            tk[cnt] = make_tok(KIND_LPAREN, off_reg, 16'd1, line_reg);
                            cnt = cnt + 2'd1;
                        end
                        ")":
                        begin
                            tk[cnt] = make_tok(KIND_RPAREN, off_reg, 16'd1, line_reg);
                            cnt = cnt + 2'd1;
                        end
                        "[":
                        begin
                            tk[cnt] = make_tok(KIND_LBRACK, off_reg, 16'd1, line_reg);
                            cnt = cnt + 2'd1;
                        end
                        "]":
                        begin
                            tk[cnt] = make_tok(KIND_RBRACK, off_reg, 16'd1, line_reg);
                            cnt = cnt + 2'd1;
                        end
                        ":":
                        begin
                            tk[cnt] = make_tok(KIND_COLON, off_reg, 16'd1, line_reg);
                            cnt = cnt + 2'd1;
                        end
                        ",":
                        begin
                            tk[cnt] = make_tok(KIND_COMMA, off_reg, 16'd1, line_reg);
                            cnt = cnt + 2'd1;
                        end
                        ".":
                        begin
                            tk[cnt] = make_tok(KIND_DOT, off_reg, 16'd1, line_reg);
                            cnt = cnt + 2'd1;
                        end
                        "+":
                        begin
                            tk[cnt] = make_tok(KIND_PLUS, off_reg, 16'd1, line_reg);
                            cnt = cnt + 2'd1;
                        end
                        ";":
                        begin
                            tk[cnt] = make_tok(KIND_SEMI, off_reg, 16'd1, line_reg);
                            cnt = cnt + 2'd1;
                        end
                        "*":
                        begin
                            tk[cnt] = make_tok(KIND_STAR, off_reg, 16'd1, line_reg);
                            cnt = cnt + 2'd1;
                        end
                        "{", "}", "-", "!", "=", "<", ">", "/":
                        begin
                            pend_next = b;
                            mode_next = MODE_PEND;
                        end
                        " ", CH_CR, "\t":
                        begin
                        end
                        CH_NL:
                        begin
                            if (line_next != LINE_MAX)
                            begin
                                line_next = line_next + 20'd1;
                            end
                        end
                        "\"":
                        begin
                            mode_next = MODE_STRING;
                        end
                        default:
                        begin
                            if (is_digit(b))
                            begin
                                mode_next = MODE_INT;
                            end
                            else if (is_alpha(b) || (b == "#") || (b == "_"))
                            begin
                                for (int i = 0; i < KEYWORD_BYTES; i++)
                                begin
                                    wbuf_next[i] = 8'd0;
                                end
                                wbuf_next[0] = b;
                                mode_next = MODE_IDENT;
                            end
                        end
                    endcase
                end
                off_next = off_reg + 24'd1;
            end
        end
        if (cnt != 2'd0)
        begin
            tk[cnt - 2'd1].last_of_run = 1'b1;
        end
    end

    always_comb
    begin
        push.count = cnt;
        for (int i = 0; i < MAX_TOK; i++)
        begin
            push.tok[i] = tk[i];
        end
    end

    assign first_line = first_line_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_vld_reg   <= 1'b0;
            mode_reg       <= MODE_IDLE;
            pend_reg       <= '0;
            start_reg      <= '0;
            off_reg        <= '0;
            line_reg       <= 20'd1;
            wlen_reg       <= '0;
            fresh_reg      <= 1'b1;
            first_line_reg <= 1'b1;
            for (int i = 0; i < KEYWORD_BYTES; i++)
            begin
                wbuf_reg[i] <= '0;
            end
        end
        else
        begin
            item_vld_reg <= item_load;
            mode_reg     <= mode_next;
            pend_reg     <= pend_next;
            start_reg    <= start_next;
            off_reg      <= off_next;
            wlen_reg     <= wlen_next;
            fresh_reg    <= fresh_next;
            wbuf_reg     <= wbuf_next;
            if (cfg_we)
            begin
                first_line_reg <= cfg_bit;
            end
            // a write before any byte of the source also reloads the line count
            if (cfg_we && fresh_reg)
            begin
                line_reg <= {19'd0, cfg_bit};
            end
            else
            begin
                line_reg <= line_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_load)
        begin
            item_reg <= item_in;
        end
    end

endmodule

### rtl/stsu_queue.sv
// Token queue: takes up to three tokens a cycle, hands out one beat a cycle while popped.
module stsu_queue (
    input  logic                  clk,
    input  logic                  rst_n,
    input  stsu_pkg::tok_push_t   push,
    input  logic                  pop,
    output logic                  head_valid,
    output stsu_pkg::tok_beat_t   head,
    output logic                  room
);
    import stsu_pkg::*;

    tok_beat_t          entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_reg, wr_next;
    logic [QPTR_W-1:0]  rd_reg, rd_next;
    logic [QCNT_W-1:0]  cnt_reg, cnt_next;

    assign head_valid = (cnt_reg != '0);
    assign head       = entry_reg[rd_reg];
    assign room       = (cnt_reg <= QCNT_W'(ACCEPT_MAX));

    always_comb
    begin
        wr_next  = wr_reg + QPTR_W'(push.count);
        rd_next  = rd_reg + QPTR_W'(pop);
        cnt_next = cnt_reg + QCNT_W'(push.count) - QCNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < MAX_TOK; i++)
        begin
            if (2'(i) < push.count)
            begin
                entry_reg[wr_reg + QPTR_W'(i)] <= push.tok[i];
            end
        end
    end

`include "script_token_scanner_unit_macros.svh"

    `STSU_ASSERT_NOW(a_cnt_bound, 1'b1, cnt_reg <= QCNT_W'(QUEUE_DEPTH))
    `STSU_ASSERT_NOW(a_no_overflow, push.count != 2'd0,
                     (cnt_reg + QCNT_W'(push.count)) <= QCNT_W'(QUEUE_DEPTH))
    `STSU_ASSERT_NOW(a_no_underflow, pop, cnt_reg != '0)
    `STSU_ASSERT_NEXT(a_pop_only, pop && (push.count == 2'd0),
                      cnt_reg == $past(cnt_reg) - QCNT_W'(1))

endmodule

### rtl/script_token_scanner_unit.sv
// Script token scanner: byte-serial maximal-munch lexer, top level.
//
// Usage:
//   src channel: one beat per source byte (operation = byte) or the end
//   mark (operation = end). The end mark closes any open token, emits an
//   eof token and starts a new source at offset 0.
//   tok channel: one beat per token, last_of_run set on the final token
//   that a source beat caused. A source beat causes zero to three tokens.
//   APB port: register 0 (byte address 0) holds first_line, bit 0.
// Order: an accepted source beat is held in the input register, from which
//   its tokens land in the output queue; the first of them is offered on tok.
// Throughput: one source beat per cycle while src_stall is low. The byte is
//   scanned by logic between the input register and the 16-entry token queue.
//   src_stall rises while the queue holds more than ten tokens, keeping room
//   for the burst of the beat in flight and of one more.
// Reset: all scan state clears, line count and first_line go to 1, the
//   queue empties. A stalled tok beat holds until taken; src keeps flowing
//   while the queue holds ten tokens or fewer.
module script_token_scanner_unit #(
    parameter int KEYWORD_BYTES = 8
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  src_valid,
    output logic                  src_stall,
    input  stsu_pkg::src_beat_t   src_data,
    output logic                  tok_valid,
    input  logic                  tok_stall,
    output stsu_pkg::tok_beat_t   tok_data,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [2:0]            paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);
    import stsu_pkg::*;

    logic       room;
    logic       src_take;
    logic       cfg_we;
    logic       first_line;
    tok_push_t  push;

    // take a source beat only while the queue can absorb two bursts
    assign src_stall = !room;
    assign src_take  = src_valid && room;

    // APB: zero wait states; decode on the word address only
    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && (paddr[2] == REG_FIRST_LINE);
    assign prdata = (paddr[2] == REG_FIRST_LINE) ? {31'd0, first_line} : 32'd0;

    stsu_core #(
        .KEYWORD_BYTES (KEYWORD_BYTES)
    ) u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_load  (src_take),
        .item_in    (src_data),
        .cfg_we     (cfg_we),
        .cfg_bit    (pwdata[0]),
        .first_line (first_line),
        .push       (push)
    );

    stsu_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .pop        (tok_valid && !tok_stall),
        .head_valid (tok_valid),
        .head       (tok_data),
        .room       (room)
    );

endmodule

### tb/script_token_scanner_unit_checker.sv
// Token predictor and scoreboard for the script token scanner.
module script_token_scanner_unit_checker
    import stsu_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      src_valid,
    input  logic      src_stall,
    input  src_beat_t src_data,
    input  logic      tok_valid,
    input  logic      tok_stall,
    input  tok_beat_t tok_data,
    input  logic      psel,
    input  logic      penable,
    input  logic      pwrite,
    input  logic [2:0] paddr,
    input  logic [31:0] pwdata,
    input  logic      pready,
    output int        fail_count,
    output int        pending_tokens
);

    localparam int KW_BYTES = 8;

    logic        first_line_q;
    scan_mode_t  mode;
    logic [7:0]  pend_op;
    logic [23:0] tok_start;
    logic [23:0] offset;
    logic [19:0] line_cnt;
    logic [7:0]  word_buf [KW_BYTES];
    logic [15:0] word_len;
    logic        fresh;

    tok_beat_t   token_queue [$];
    tok_beat_t   burst [$];

    assign pending_tokens = token_queue.size();

    function automatic logic [5:0] op_kind(input logic [7:0] op);
        case (op)
            "{": return KIND_LBRACE;
            "}": return KIND_RBRACE;
            "-": return KIND_MINUS;
            "!": return KIND_BANG;
            "=": return KIND_EQUAL;
            "<": return KIND_LESS;
            ">": return KIND_GREATER;
            default: return KIND_SLASH;
        endcase
    endfunction

    function automatic bit dig(input logic [7:0] b);
        return b >= "0" && b <= "9";
    endfunction

    function automatic bit alpha(input logic [7:0] b);
        return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
    endfunction

    // Match the buffered word against the keyword list.
    function automatic logic [5:0] classify_word();
        string kws [19];
        kws = '{"and", "class", "else", "false", "for", "fun", "if", "nil", "or",
                "print", "return", "super", "this", "true", "var", "while",
                "Listen", "Delegate", "Animate"};
        for (int k = 0; k < 19; k++) begin
            bit hit;
            hit = (word_len == 16'(kws[k].len())) && kws[k].len() <= KW_BYTES;
            for (int j = 0; j < kws[k].len() && hit; j++)
                if (word_buf[j] != kws[k][j]) hit = 0;
            if (hit) return KIND_KW0 + 6'(k);
        end
        return KIND_IDENT;
    endfunction

    task automatic push_tok(input logic [5:0] kind, input logic [23:0] st,
                            input logic [15:0] len);
        tok_beat_t t;
        t.token_kind   = kind;
        t.start_offset = st;
        t.token_length = len;
        t.line_number  = line_cnt;
        t.last_of_run  = 1'b0;
        burst.push_back(t);
    endtask

    task automatic bump_line();
        if (line_cnt != LINE_MAX) line_cnt++;
    endtask

    task automatic bump_len();
        if (word_len != LEN_MAX) word_len++;
    endtask

    task automatic close_open();
        case (mode)
            MODE_PEND:  push_tok(op_kind(pend_op), tok_start, 16'd1);
            MODE_IDENT: push_tok(classify_word(), tok_start, word_len);
            MODE_INT, MODE_FRAC: push_tok(KIND_NUMBER, tok_start, word_len);
            MODE_DOT:
            begin
                push_tok(KIND_NUMBER, tok_start, word_len);
                push_tok(KIND_DOT, offset - 24'd1, 16'd1);
            end
            default: ;
        endcase
        mode = MODE_IDLE;
    endtask

    task automatic start_token(input logic [7:0] b, input logic [23:0] pos);
        tok_start = pos;
        word_len  = 16'd1;
        case (b)
            "(": push_tok(KIND_LPAREN, pos, 16'd1);
            ")": push_tok(KIND_RPAREN, pos, 16'd1);
            "[": push_tok(KIND_LBRACK, pos, 16'd1);
            "]": push_tok(KIND_RBRACK, pos, 16'd1);
            ":": push_tok(KIND_COLON, pos, 16'd1);
            ",": push_tok(KIND_COMMA, pos, 16'd1);
            ".": push_tok(KIND_DOT, pos, 16'd1);
            "+": push_tok(KIND_PLUS, pos, 16'd1);
            ";": push_tok(KIND_SEMI, pos, 16'd1);
            "*": push_tok(KIND_STAR, pos, 16'd1);
            "{", "}", "-", "!", "=", "<", ">", "/":
            begin
                pend_op = b;
                mode    = MODE_PEND;
            end
            " ", CH_CR, 8'h09: ;
            CH_NL: bump_line();
            "\"": mode = MODE_STRING;
            default:
                if (dig(b))
                    mode = MODE_INT;
                else if (alpha(b) || b == "#" || b == "_")
                begin
                    foreach (word_buf[i]) word_buf[i] = 8'h00;
                    word_buf[0] = b;
                    mode = MODE_IDENT;
                end
        endcase
    endtask

    task automatic scan_beat(input src_beat_t beat);
        logic [7:0]  b;
        logic [23:0] pos;
        bit          taken;
        b     = beat.source_byte;
        pos   = offset;
        taken = 1;
        burst.delete();
        if (beat.operation == OP_END)
        begin
            close_open();
            push_tok(KIND_EOF, 24'd0, 16'd0);
            tok_start = 0;
            offset    = 0;
            word_len  = 0;
            line_cnt  = 20'(first_line_q);
            fresh     = 1;
        end
        else
        begin
            fresh = 0;
            case (mode)
                MODE_PEND:
                begin
                    bit dbl;
                    dbl = (pend_op == "{" && b == "{") || (pend_op == "}" && b == "}")
                        || (pend_op == "-" && b == ">")
                        || ((pend_op == "!" || pend_op == "=" || pend_op == "<"
                             || pend_op == ">") && b == "=");
                    if (pend_op == "/" && b == "/")
                        mode = MODE_COMMENT;
                    else if (dbl)
                    begin
                        push_tok(op_kind(pend_op) + 6'd1, tok_start, 16'd2);
                        mode = MODE_IDLE;
                    end
                    else
                    begin
                        push_tok(op_kind(pend_op), tok_start, 16'd1);
                        mode  = MODE_IDLE;
                        taken = 0;
                    end
                end
                MODE_COMMENT:
                    if (b == CH_NL)
                    begin
                        mode  = MODE_IDLE;
                        taken = 0;
                    end
                MODE_STRING:
                begin
                    bump_len();
                    if (b == "\"")
                    begin
                        push_tok(KIND_STRING, tok_start, word_len);
                        mode = MODE_IDLE;
                    end
                    else if (b == CH_NL)
                        bump_line();
                end
                MODE_IDENT:
                    if (alpha(b) || dig(b) || b == "_")
                    begin
                        if (word_len < KW_BYTES) word_buf[word_len] = b;
                        bump_len();
                    end
                    else
                    begin
                        push_tok(classify_word(), tok_start, word_len);
                        mode  = MODE_IDLE;
                        taken = 0;
                    end
                MODE_INT, MODE_FRAC:
                    if (dig(b))
                        bump_len();
                    else if (b == "." && mode == MODE_INT)
                        mode = MODE_DOT;
                    else
                    begin
                        push_tok(KIND_NUMBER, tok_start, word_len);
                        mode  = MODE_IDLE;
                        taken = 0;
                    end
                MODE_DOT:
                    if (dig(b))
                    begin
                        bump_len();
                        bump_len();
                        mode = MODE_FRAC;
                    end
                    else
                    begin
                        close_open();
                        taken = 0;
                    end
                default:
                begin
                    mode  = MODE_IDLE;
                    taken = 0;
                end
            endcase
            if (!taken) start_token(b, pos);
            offset = pos + 24'd1;
        end
        if (burst.size() > 0) burst[burst.size()-1].last_of_run = 1'b1;
        foreach (burst[i]) token_queue.push_back(burst[i]);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_line_q = 1'b1;
            mode         = MODE_IDLE;
            pend_op      = 0;
            tok_start    = 0;
            offset       = 0;
            line_cnt     = 20'd1;
            foreach (word_buf[i]) word_buf[i] = 8'h00;
            word_len     = 0;
            fresh        = 1;
            fail_count   = 0;
            token_queue.delete();
        end
        else
        begin
            if (psel && penable && pwrite && pready && paddr == 3'd0)
            begin
                first_line_q = pwdata[0];
                if (fresh) line_cnt = 20'(pwdata[0]);
            end
            if (src_valid && !src_stall) scan_beat(src_data);
            if (tok_valid && !tok_stall)
            begin
                if (token_queue.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected token %p", tok_data);
                end
                else
                begin
                    tok_beat_t want;
                    want = token_queue.pop_front();
                    if (want !== tok_data)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("token mismatch: expected %p got %p", want, tok_data);
                    end
                end
            end
        end
    end

endmodule

### tb/script_token_scanner_unit_tb.sv
// Stimulus and verdict for the script token scanner.
module script_token_scanner_unit_tb;
    import stsu_pkg::*;

    logic        clk = 0;
    logic        rst_n = 0;
    logic        src_valid = 0;
    logic        src_stall;
    src_beat_t   src_data = '0;
    logic        tok_valid;
    logic        tok_stall = 0;
    tok_beat_t   tok_data;
    logic        psel = 0, penable = 0, pwrite = 0;
    logic [2:0]  paddr = 0;
    logic [31:0] pwdata = 0;
    logic [31:0] prdata;
    logic        pready;
    int          fail_count;
    int          pending_tokens;

    // Receiver behavior: 0 free, 1 random stall, 2 long hold-off.
    int          sink_mode = 1;
    int          src_idle_pct = 22;

    always #5 clk = ~clk;

    script_token_scanner_unit u_dut (
        .clk, .rst_n, .src_valid, .src_stall, .src_data, .tok_valid, .tok_stall,
        .tok_data, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
    );

    script_token_scanner_unit_checker u_chk (
        .clk, .rst_n, .src_valid, .src_stall, .src_data, .tok_valid, .tok_stall,
        .tok_data, .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
        .fail_count, .pending_tokens
    );

    // Drive the receiver stall.
    always @(posedge clk)
    begin
        if (sink_mode == 2)
            tok_stall <= 1'b1;
        else if (sink_mode == 1)
            tok_stall <= ($urandom_range(99) < 22);
        else
            tok_stall <= 1'b0;
    end

    // Offer one beat, idling at random first; hold it until taken.
    // Valid stays high after the beat until an idle or drain() drops it; the next beat replaces it.
    task automatic send_beat(input logic op, input logic [7:0] b);
        while ($urandom_range(99) < src_idle_pct)
        begin
            src_valid <= 1'b0;
            @(posedge clk);
        end
        src_valid <= 1'b1;
        src_data  <= '{operation: op, source_byte: b};
        @(posedge clk);
        while (src_stall) @(posedge clk);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) send_beat(OP_BYTE, s[i]);
    endtask

    // Drop valid, drain every expected token, then let the last burst settle.
    task automatic drain();
        src_valid <= 1'b0;
        while (pending_tokens != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_first_line(input logic v);
        psel   <= 1'b1;
        pwrite <= 1'b1;
        paddr  <= {2'b0, REG_FIRST_LINE};
        pwdata <= {31'b0, v};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Pick a well-formed lexeme or some noise.
    function automatic string random_lexeme();
        string pool [] = '{"and", "class", "else", "false", "for", "fun", "if", "nil",
            "or", "print", "return", "super", "this", "true", "var", "while", "Listen",
            "Delegate", "Animate", "#id", "_x9", "verylongword", "12", "3.14", "7.",
            "\"str\"", "\"a\nb\"", "{{", "}}", "->", "!=", "==", "<=", ">=", "{", "}",
            "-", "!", "=", "<", ">", "/", "// note\n", "(", ")", "[", "]", ":", ",",
            ".", "+", ";", "*", " ", "\n", "\t", "\r"};
        string s;
        int r;
        r = $urandom_range(99);
        if (r < 80) return pool[$urandom_range(pool.size() - 1)];
        s = " ";
        s[0] = 8'($urandom_range(255));
        if (s[0] == 8'h00) s[0] = 8'h80;
        return s;
    endfunction

    initial
    begin
        #2_000_000;
        $display("script_token_scanner_unit test failed");
        $finish;
    end

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: every punctuator, keywords, number forms, strings, comments.
        send_text("( ) [ ] : { {{ } }} , . - -> + ; * ! != = == < <= > >= / ");
        send_text("and Delegate Animate Listen #tag _u longidentifier 12.5 7.x 9");
        send_text(" \"multi\nline\" // gone\n\x80\xff@");
        send_beat(OP_END, 8'h00);
        send_text("\"open");
        send_beat(OP_END, 8'hFF);
        drain();

        write_first_line(1'b0);
        send_text("3. // tail");
        send_beat(OP_END, 8'h00);
        drain();

        // Random sources with random content; phase 2 runs with no idling.
        for (int ph = 0; ph < 4; ph++)
        begin
            write_first_line(ph[0]);
            sink_mode    = (ph == 2) ? 0 : 1;
            src_idle_pct = (ph == 2) ? 0 : 22;
            for (int k = 0; k < ((ph == 2) ? 12 : 4); k++)
            begin
                string s;
                s = random_lexeme();
                send_text(s);
                if ($urandom_range(15) == 0) send_beat(OP_END, 8'($urandom_range(255)));
            end
            send_beat(OP_END, 8'h00);
            drain();
        end

        // Hold off the receiver while the source keeps pushing.
        fork
            begin
                sink_mode = 2;
                repeat (300) @(posedge clk);
                sink_mode = 1;
            end
            begin
                repeat (16) send_text("(");
                send_beat(OP_END, 8'h00);
                src_valid <= 1'b0;
            end
        join
        drain();
        repeat (20) @(posedge clk);

        if (fail_count == 0 && pending_tokens == 0)
            $display("script_token_scanner_unit test passed");
        else
            $display("script_token_scanner_unit test failed");
        $finish;
    end

endmodule

### script_token_scanner_unit.f
+incdir+rtl
rtl/stsu_pkg.sv
rtl/stsu_core.sv
rtl/stsu_queue.sv
rtl/script_token_scanner_unit.sv
tb/script_token_scanner_unit_checker.sv
tb/script_token_scanner_unit_tb.sv
